@@ hdl/i2ctsb_pkg.sv @@
// Shared types and constants for the I2C target split buffer.
package i2ctsb_pkg;

   // Bus event and application access codes carried on req_action.
   localparam logic [2:0] ACT_ADDR_WRITE   = 3'd0;
   localparam logic [2:0] ACT_ADDR_READ    = 3'd1;
   localparam logic [2:0] ACT_MASTER_READ  = 3'd2;
   localparam logic [2:0] ACT_MASTER_WRITE = 3'd3;
   localparam logic [2:0] ACT_STOP         = 3'd4;
   localparam logic [2:0] ACT_BAD_STATUS   = 3'd5;
   localparam logic [2:0] ACT_LOAD_SEND    = 3'd6;
   localparam logic [2:0] ACT_READ_RX      = 3'd7;

   // Register indexes on the CSR port (byte address divided by four).
   localparam logic [1:0] REG_SEND_LENGTH   = 2'd0;
   localparam logic [1:0] REG_RECEIVE_SIZE  = 2'd1;
   localparam logic [1:0] REG_SEGMENT_COUNT = 2'd2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Memory depths; both are addressed by the 8-bit index field.
   localparam logic [8:0] TX_DEPTH = 9'd256;
   localparam logic [8:0] RX_DEPTH = 9'd256;
   localparam int         MEM_AW   = 8;

   localparam logic [8:0] SEND_LENGTH_RST   = 9'd0;
   localparam logic [8:0] RECEIVE_SIZE_RST  = 9'd256;
   localparam logic [1:0] SEGMENT_COUNT_RST = 2'd1;

   localparam logic [7:0] FILLER_BYTE = 8'hFF;

   // What an accepted transaction leaves for the result stage while the
   // memory read is in flight.
   typedef struct packed {
      logic       tx_valid;
      logic       tx_from_mem;
      logic       read_request;
      logic [7:0] request_byte;
      logic       data_sent;
      logic       data_ready;
      logic       ready_segment;
      logic       reinit;
      logic       read_back;
   } s1_type;

endpackage

@@ hdl/i2c_target_split_buffer.sv @@
// Top level of the I2C target split buffer: event decode, memories and result register.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | action, data_byte, index
//   rsp     | out       | rsp_valid / rsp_ready  | tx_valid, tx_byte, read_request, request_byte,
//           |           |                        | data_sent, data_ready, ready_segment, reinit,
//           |           |                        | read_back_byte
//   csr     | in        | APB write, pready high | send_length, receive_size, segment_count
//
// One transaction per cycle is accepted while req_ready is high; each yields one result.
// Acceptance updates the pointers and issues any read or write of the send or receive
// memory; the read stage then captures the registered read data into the result register.
// Reset is synchronous, clears pointers and valid flags and loads the configuration
// defaults; memory contents are undefined until written. A stalled rsp side holds the
// result register and one more transaction in the read stage before req_ready drops.
module i2c_target_split_buffer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_action,
   input  logic [7:0]                        req_data_byte,
   input  logic [7:0]                        req_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_tx_valid,
   output logic [7:0]                        rsp_tx_byte,
   output logic                              rsp_read_request,
   output logic [7:0]                        rsp_request_byte,
   output logic                              rsp_data_sent,
   output logic                              rsp_data_ready,
   output logic                              rsp_ready_segment,
   output logic                              rsp_reinit,
   output logic [7:0]                        rsp_read_back_byte,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [i2ctsb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [i2ctsb_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [i2ctsb_pkg::CSR_DATA_W-1:0] prdata,
   output logic                              pready
);

   // Memories.
   logic [7:0] send_mem    [0:int'(i2ctsb_pkg::TX_DEPTH)-1];
   logic [7:0] receive_mem [0:int'(i2ctsb_pkg::RX_DEPTH)-1];

   // Configuration registers.
   logic [8:0] send_length_ff, send_length_in;
   logic [8:0] receive_size_ff, receive_size_in;
   logic [1:0] segment_count_ff, segment_count_in;

   // Protocol state.
   logic [8:0] send_pos_ff, send_pos_in;
   logic [8:0] recv_pos_ff, recv_pos_in;
   logic       cur_seg_ff, cur_seg_in;
   logic       reported_ff, reported_in;
   logic [7:0] last_rx_ff, last_rx_in;

   // Read stage and result register.
   logic                  s1_valid_ff, s1_valid_in;
   i2ctsb_pkg::s1_type    s1_ff, s1_in;
   logic [7:0]            tx_rdata_ff;
   logic [7:0]            rx_rdata_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   i2ctsb_pkg::s1_type    rsp_ff;
   logic [7:0]            rsp_tx_byte_ff, rsp_tx_byte_in;
   logic [7:0]            rsp_rb_byte_ff, rsp_rb_byte_in;

   logic                      req_accept;
   logic                      s1_adv;
   logic                      csr_write;
   logic [1:0]                csr_index;
   logic [8:0]                eff_send_len;
   logic [8:0]                eff_rx_size;
   logic                      two_seg;
   logic [8:0]                seg_size;
   logic                      eff_cur;
   logic [8:0]                tx_pos;
   logic                      tx_rd_en;
   logic [8:0]                rx_addr;
   logic                      rx_wr_en;
   logic                      tx_wr_en;
   logic                      rx_rd_en;

   // Handshakes.
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_adv;
   assign req_accept = req_valid && req_ready;
   assign csr_write  = psel && penable && pwrite;
   assign csr_index  = paddr[3:2];
   assign pready     = 1'b1;

   // Effective configuration.
   assign eff_send_len = (send_length_ff > i2ctsb_pkg::TX_DEPTH) ? i2ctsb_pkg::TX_DEPTH
                                                                 : send_length_ff;
   always_comb begin
      if (receive_size_ff == 9'd0) begin
         eff_rx_size = 9'd1;
      end else if (receive_size_ff > i2ctsb_pkg::RX_DEPTH) begin
         eff_rx_size = i2ctsb_pkg::RX_DEPTH;
      end else begin
         eff_rx_size = receive_size_ff;
      end
   end
   // Segment counts of two and three both select two segments.
   assign two_seg  = segment_count_ff[1];
   assign seg_size = two_seg ? {1'b0, eff_rx_size[8:1]} : eff_rx_size;
   assign eff_cur  = two_seg && cur_seg_ff;

   // An address read restarts the send pointer before the first byte goes out.
   assign tx_pos  = (req_action == i2ctsb_pkg::ACT_ADDR_READ) ? 9'd0 : send_pos_ff;
   assign rx_addr = eff_cur ? (seg_size + recv_pos_ff) : recv_pos_ff;

   always_comb begin
      send_pos_in = send_pos_ff;
      recv_pos_in = recv_pos_ff;
      cur_seg_in  = cur_seg_ff;
      reported_in = reported_ff;
      last_rx_in  = last_rx_ff;
      tx_rd_en    = 1'b0;
      rx_wr_en    = 1'b0;
      tx_wr_en    = 1'b0;
      rx_rd_en    = 1'b0;
      s1_in       = '0;
      if (req_accept) begin
         unique case (req_action) inside
            i2ctsb_pkg::ACT_ADDR_WRITE: begin
               reported_in = 1'b0;
               recv_pos_in = 9'd0;
               send_pos_in = 9'd0;
            end
            i2ctsb_pkg::ACT_ADDR_READ, i2ctsb_pkg::ACT_MASTER_READ: begin
               if (req_action == i2ctsb_pkg::ACT_ADDR_READ) begin
                  recv_pos_in        = 9'd0;
                  s1_in.read_request = 1'b1;
                  s1_in.request_byte = last_rx_ff;
               end
               s1_in.tx_valid = 1'b1;
               if (tx_pos < eff_send_len) begin
                  tx_rd_en          = 1'b1;
                  s1_in.tx_from_mem = 1'b1;
                  send_pos_in       = tx_pos + 9'd1;
               end else begin
                  send_pos_in     = tx_pos;
                  s1_in.data_sent = 1'b1;
               end
            end
            i2ctsb_pkg::ACT_MASTER_WRITE: begin
               last_rx_in = req_data_byte;
               // Bytes beyond the segment size are dropped.
               if (recv_pos_ff < seg_size) begin
                  rx_wr_en    = 1'b1;
                  recv_pos_in = recv_pos_ff + 9'd1;
               end
            end
            i2ctsb_pkg::ACT_STOP: begin
               if (!reported_ff) begin
                  s1_in.data_ready    = 1'b1;
                  s1_in.ready_segment = eff_cur;
                  cur_seg_in          = two_seg && !eff_cur;
                  reported_in         = 1'b1;
               end
            end
            i2ctsb_pkg::ACT_BAD_STATUS: begin
               s1_in.reinit = 1'b1;
            end
            i2ctsb_pkg::ACT_LOAD_SEND: begin
               tx_wr_en = 1'b1;
            end
            i2ctsb_pkg::ACT_READ_RX: begin
               rx_rd_en        = 1'b1;
               s1_in.read_back = 1'b1;
            end
            default: begin
            end
         endcase
      end
      // A new send length restarts transmission from the first byte.
      if (csr_write && csr_index == i2ctsb_pkg::REG_SEND_LENGTH) begin
         send_pos_in = 9'd0;
      end
   end

   // Configuration writes.
   always_comb begin
      send_length_in   = send_length_ff;
      receive_size_in  = receive_size_ff;
      segment_count_in = segment_count_ff;
      if (csr_write) begin
         unique case (csr_index)
            i2ctsb_pkg::REG_SEND_LENGTH:   send_length_in   = pwdata[8:0];
            i2ctsb_pkg::REG_RECEIVE_SIZE:  receive_size_in  = pwdata[8:0];
            i2ctsb_pkg::REG_SEGMENT_COUNT: segment_count_in = pwdata[1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         i2ctsb_pkg::REG_SEND_LENGTH:   prdata = {23'd0, send_length_ff};
         i2ctsb_pkg::REG_RECEIVE_SIZE:  prdata = {23'd0, receive_size_ff};
         i2ctsb_pkg::REG_SEGMENT_COUNT: prdata = {30'd0, segment_count_ff};
         default:                       prdata = '0;
      endcase
   end

   // Memories: at most one access per accepted transaction.
   always_ff @(posedge clock) begin
      if (tx_wr_en) begin
         send_mem[req_index] <= req_data_byte;
      end
      if (tx_rd_en) begin
         tx_rdata_ff <= send_mem[tx_pos[i2ctsb_pkg::MEM_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (rx_wr_en) begin
         receive_mem[rx_addr[i2ctsb_pkg::MEM_AW-1:0]] <= req_data_byte;
      end
      if (rx_rd_en) begin
         rx_rdata_ff <= receive_mem[req_index];
      end
   end

   // Read stage and result register.
   assign s1_valid_in = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      rsp_tx_byte_in = 8'd0;
      if (s1_ff.tx_valid) begin
         rsp_tx_byte_in = s1_ff.tx_from_mem ? tx_rdata_ff : i2ctsb_pkg::FILLER_BYTE;
      end
      rsp_rb_byte_in = s1_ff.read_back ? rx_rdata_ff : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         rsp_ff         <= s1_ff;
         rsp_tx_byte_ff <= rsp_tx_byte_in;
         rsp_rb_byte_ff <= rsp_rb_byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         send_length_ff   <= i2ctsb_pkg::SEND_LENGTH_RST;
         receive_size_ff  <= i2ctsb_pkg::RECEIVE_SIZE_RST;
         segment_count_ff <= i2ctsb_pkg::SEGMENT_COUNT_RST;
         send_pos_ff      <= 9'd0;
         recv_pos_ff      <= 9'd0;
         cur_seg_ff       <= 1'b0;
         reported_ff      <= 1'b0;
         last_rx_ff       <= 8'd0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         send_length_ff   <= send_length_in;
         receive_size_ff  <= receive_size_in;
         segment_count_ff <= segment_count_in;
         send_pos_ff      <= send_pos_in;
         recv_pos_ff      <= recv_pos_in;
         cur_seg_ff       <= cur_seg_in;
         reported_ff      <= reported_in;
         last_rx_ff       <= last_rx_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tx_valid       = rsp_ff.tx_valid;
   assign rsp_tx_byte        = rsp_tx_byte_ff;
   assign rsp_read_request   = rsp_ff.read_request;
   assign rsp_request_byte   = rsp_ff.request_byte;
   assign rsp_data_sent      = rsp_ff.data_sent;
   assign rsp_data_ready     = rsp_ff.data_ready;
   assign rsp_ready_segment  = rsp_ff.ready_segment;
   assign rsp_reinit         = rsp_ff.reinit;
   assign rsp_read_back_byte = rsp_rb_byte_ff;

endmodule

@@ hdl/i2ctsb_checker.sv @@
// Port-level checks for the I2C target split buffer, bound to the top level.
module i2ctsb_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_tx_valid,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_data_sent,
   input logic       rsp_data_ready,
   input logic       rsp_reinit,
   input logic [7:0] rsp_read_back_byte
);

   // No result may survive a reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte)
         && $stable(rsp_tx_valid) && $stable(rsp_data_ready)
         && $stable(rsp_read_back_byte) && $stable(rsp_reinit))
      else $error("result changed while stalled");

   // A result carries at most one kind of event.
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_tx_valid, rsp_data_ready, rsp_reinit}))
      else $error("result carries more than one event");

   // Running past the send data always sends the filler byte.
   a_overrun_filler: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_sent |-> rsp_tx_valid
         && rsp_tx_byte == i2ctsb_pkg::FILLER_BYTE)
      else $error("overrun without filler byte");

endmodule

bind i2c_target_split_buffer i2ctsb_checker u_i2ctsb_checker (.*);

@@ dv/i2c_target_split_buffer_test.sv @@
// Self-checking testbench for the I2C target split buffer: bus event traffic against a predictor.
`timescale 1ns / 100ps

module i2c_target_split_buffer_test;

   localparam logic [1:0] REG_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       read_request;
      logic [7:0] request_byte;
      logic       data_sent;
      logic       data_ready;
      logic       ready_segment;
      logic       reinit;
      logic [7:0] read_back_byte;
   } outcome_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  data_byte;
      logic [7:0]  index;
      outcome_type outcome;
   } bus_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_action = i2ctsb_pkg::ACT_BAD_STATUS;
   logic [7:0]  req_data_byte = 8'h00;
   logic [7:0]  req_index = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_read_request;
   logic [7:0]  rsp_request_byte;
   logic        rsp_data_sent;
   logic        rsp_data_ready;
   logic        rsp_ready_segment;
   logic        rsp_reinit;
   logic [7:0]  rsp_read_back_byte;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [i2ctsb_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [i2ctsb_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [i2ctsb_pkg::CSR_DATA_W-1:0] prdata;
   logic        pready;

   i2c_target_split_buffer dut (.*);

   always #2 clock = ~clock;

   // Predictor state and configuration.
   logic [7:0] send_mem [256];
   logic [7:0] rx_mem [256];
   bit         send_written [256];
   bit         rx_written [256];
   int         rx_written_total;
   int         send_pos;
   int         rx_pos;
   bit         cur_segment;
   bit         reported;
   logic [7:0] last_rx;
   logic [8:0] cfg_send_length = i2ctsb_pkg::SEND_LENGTH_RST;
   logic [8:0] cfg_receive_size = i2ctsb_pkg::RECEIVE_SIZE_RST;
   logic [1:0] cfg_segment_count = i2ctsb_pkg::SEGMENT_COUNT_RST;

   bus_event_type pending_events[$];
   outcome_type   awaited_outcomes[$];
   bus_event_type in_flight;
   int         items_queued;
   int         results_seen;
   int         mismatches;
   int         dropped_bytes;
   int         filler_sends;
   int         segment_reports;
   int         settings_used;
   int         idle_pct;
   int         stall_pct;
   bit         calm;
   int         send_hold;
   int         recv_hold;
   int         cycles;

   function automatic int send_bytes();
      return (cfg_send_length > i2ctsb_pkg::TX_DEPTH) ? int'(i2ctsb_pkg::TX_DEPTH)
                                                      : int'(cfg_send_length);
   endfunction

   function automatic int rx_bytes();
      if (cfg_receive_size == 0) return 1;
      return (cfg_receive_size > i2ctsb_pkg::RX_DEPTH) ? int'(i2ctsb_pkg::RX_DEPTH)
                                                       : int'(cfg_receive_size);
   endfunction

   function automatic int segments_in_use();
      if (cfg_segment_count == 0) return 1;
      return (cfg_segment_count > 2) ? 2 : int'(cfg_segment_count);
   endfunction

   function automatic outcome_type predict_event(logic [2:0] act, logic [7:0] data,
                                                 logic [7:0] idx);
      outcome_type o;
      int seg_size;
      int addr;
      int seg;
      o = '0;
      seg = (segments_in_use() == 2) ? int'(cur_segment) : 0;
      case (act) inside
         i2ctsb_pkg::ACT_ADDR_WRITE: begin
            reported = 1'b0;
            rx_pos = 0;
            send_pos = 0;
         end
         i2ctsb_pkg::ACT_ADDR_READ, i2ctsb_pkg::ACT_MASTER_READ: begin
            if (act == i2ctsb_pkg::ACT_ADDR_READ) begin
               rx_pos = 0;
               send_pos = 0;
               o.read_request = 1'b1;
               o.request_byte = last_rx;
            end
            o.tx_valid = 1'b1;
            if (send_pos < send_bytes()) begin
               o.tx_byte = send_mem[send_pos];
               send_pos++;
            end else begin
               o.tx_byte = i2ctsb_pkg::FILLER_BYTE;
               o.data_sent = 1'b1;
               filler_sends++;
            end
         end
         i2ctsb_pkg::ACT_MASTER_WRITE: begin
            last_rx = data;
            seg_size = rx_bytes() / segments_in_use();
            if (rx_pos < seg_size) begin
               addr = seg * seg_size + rx_pos;
               if (addr < int'(i2ctsb_pkg::RX_DEPTH)) begin
                  rx_mem[addr] = data;
                  if (!rx_written[addr]) rx_written_total++;
                  rx_written[addr] = 1'b1;
               end
               rx_pos++;
            end else begin
               dropped_bytes++;
            end
         end
         i2ctsb_pkg::ACT_STOP: begin
            if (!reported) begin
               o.data_ready = 1'b1;
               o.ready_segment = seg[0];
               seg++;
               if (seg >= segments_in_use()) seg = 0;
               cur_segment = seg[0];
               reported = 1'b1;
               segment_reports++;
            end
         end
         i2ctsb_pkg::ACT_BAD_STATUS: o.reinit = 1'b1;
         i2ctsb_pkg::ACT_LOAD_SEND: begin
            send_mem[idx] = data;
            send_written[idx] = 1'b1;
         end
         default: o.read_back_byte = rx_mem[idx];
      endcase
      return o;
   endfunction

   // Send memory entry that this event would read before anything was loaded there, or -1.
   function automatic int unloaded_send_entry(logic [2:0] act);
      if (act == i2ctsb_pkg::ACT_ADDR_READ && send_bytes() > 0 && !send_written[0]) return 0;
      if (act == i2ctsb_pkg::ACT_MASTER_READ && send_pos < send_bytes()
          && !send_written[send_pos])
         return send_pos;
      return -1;
   endfunction

   function automatic int written_rx_entry();
      int k;
      int start;
      if (rx_written_total == 0) return -1;
      start = $urandom_range(0, 255);
      for (k = 0; k < 256; k++)
         if (rx_written[(start + k) % 256]) return (start + k) % 256;
      return -1;
   endfunction

   task automatic queue_one(logic [2:0] act, logic [7:0] data, logic [7:0] idx);
      bus_event_type ev;
      ev.action = act;
      ev.data_byte = data;
      ev.index = idx;
      ev.outcome = predict_event(act, data, idx);
      pending_events.push_back(ev);
      items_queued++;
   endtask

   // Never read unwritten memory: load the entry first, read another one, or send a bad status.
   task automatic add_event(logic [2:0] act, logic [7:0] data, logic [7:0] idx);
      int hole;
      hole = unloaded_send_entry(act);
      if (hole >= 0) queue_one(i2ctsb_pkg::ACT_LOAD_SEND, 8'($urandom), 8'(hole));
      if (act == i2ctsb_pkg::ACT_READ_RX && !rx_written[idx]) begin
         hole = written_rx_entry();
         if (hole < 0) act = i2ctsb_pkg::ACT_BAD_STATUS;
         else idx = 8'(hole);
      end
      queue_one(act, data, idx);
   endtask

   task automatic add_random(logic [2:0] act);
      add_event(act, 8'($urandom), 8'($urandom));
   endtask

   task automatic wait_drained();
      while (results_seen != items_queued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] reg_idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_read(input logic [1:0] reg_idx, output logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {reg_idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      // Sample in the middle of the access cycle so the result cannot race the edge.
      @(negedge clock);
      while (!pready) @(negedge clock);
      value = prdata;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic set_register(logic [1:0] reg_idx, logic [31:0] value);
      logic [31:0] readback;
      csr_write(reg_idx, value);
      csr_read(reg_idx, readback);
      case (reg_idx)
         i2ctsb_pkg::REG_SEND_LENGTH: begin
            cfg_send_length = value[8:0];
            send_pos = 0;
            check_field("send_length", {23'd0, value[8:0]}, readback);
         end
         i2ctsb_pkg::REG_RECEIVE_SIZE: begin
            cfg_receive_size = value[8:0];
            check_field("receive_size", {23'd0, value[8:0]}, readback);
         end
         default: begin
            cfg_segment_count = value[1:0];
            check_field("segment_count", {30'd0, value[1:0]}, readback);
         end
      endcase
   endtask

   task automatic configure(int send_len, int rx_size, int segs);
      wait_drained();
      set_register(i2ctsb_pkg::REG_SEND_LENGTH, 32'(send_len));
      set_register(i2ctsb_pkg::REG_RECEIVE_SIZE, 32'(rx_size));
      set_register(i2ctsb_pkg::REG_SEGMENT_COUNT, 32'(segs));
      settings_used++;
      idle_pct = $urandom_range(0, 40);
      stall_pct = $urandom_range(0, 40);
   endtask

   task automatic random_traffic(int count);
      int stop_at;
      int len;
      int pick;
      int k;
      int base;
      stop_at = items_queued + count;
      while (items_queued < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            add_random(i2ctsb_pkg::ACT_ADDR_WRITE);
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 260) : $urandom_range(0, 8);
            for (k = 0; k < len; k++) add_random(i2ctsb_pkg::ACT_MASTER_WRITE);
            if ($urandom_range(0, 9) != 0) add_random(i2ctsb_pkg::ACT_STOP);
         end else if (pick < 60) begin
            add_random(i2ctsb_pkg::ACT_ADDR_READ);
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, send_bytes() + 3)
                                               : $urandom_range(0, 6);
            for (k = 0; k < len; k++) add_random(i2ctsb_pkg::ACT_MASTER_READ);
            if ($urandom_range(0, 9) != 0) add_random(i2ctsb_pkg::ACT_STOP);
         end else if (pick < 75) begin
            base = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 255);
            len = $urandom_range(1, 8);
            for (k = 0; k < len; k++)
               add_event(i2ctsb_pkg::ACT_LOAD_SEND, 8'($urandom), 8'(base + k));
         end else if (pick < 85) begin
            len = $urandom_range(1, 4);
            for (k = 0; k < len; k++) add_random(i2ctsb_pkg::ACT_READ_RX);
         end else begin
            add_random(3'($urandom));
         end
      end
   endtask

   // Driver: presents queued bus events, with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_hold = 0;
      end else begin
         if (req_valid && req_ready) awaited_outcomes.push_back(in_flight.outcome);
         if (!req_valid || req_ready) begin
            if (send_hold == 0 && !calm && $urandom_range(0, 99) < idle_pct)
               send_hold = $urandom_range(1, 5);
            if (send_hold != 0) begin
               send_hold--;
               req_valid <= 1'b0;
            end else if (pending_events.size() != 0) begin
               in_flight = pending_events.pop_front();
               req_valid <= 1'b1;
               req_action <= in_flight.action;
               req_data_byte <= in_flight.data_byte;
               req_index <= in_flight.index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every result transaction against the oldest prediction.
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (awaited_outcomes.size() == 0) begin
               $error("result transaction arrived with nothing outstanding");
               mismatches++;
            end else begin
               want = awaited_outcomes.pop_front();
               check_field("tx_valid", 32'(want.tx_valid), 32'(rsp_tx_valid));
               check_field("tx_byte", 32'(want.tx_byte), 32'(rsp_tx_byte));
               check_field("read_request", 32'(want.read_request), 32'(rsp_read_request));
               check_field("request_byte", 32'(want.request_byte), 32'(rsp_request_byte));
               check_field("data_sent", 32'(want.data_sent), 32'(rsp_data_sent));
               check_field("data_ready", 32'(want.data_ready), 32'(rsp_data_ready));
               check_field("ready_segment", 32'(want.ready_segment),
                           32'(rsp_ready_segment));
               check_field("reinit", 32'(want.reinit), 32'(rsp_reinit));
               check_field("read_back_byte", 32'(want.read_back_byte),
                           32'(rsp_read_back_byte));
            end
         end
         if (recv_hold == 0 && !calm && $urandom_range(0, 99) < stall_pct)
            recv_hold = $urandom_range(1, 5);
         if (recv_hold != 0) begin
            recv_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      idle_pct = 30;
      stall_pct = 30;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: no send data, one segment of the full receive memory.
      add_event(i2ctsb_pkg::ACT_BAD_STATUS, 8'h00, 8'h00);
      add_event(i2ctsb_pkg::ACT_STOP, 8'h00, 8'h00);
      add_event(i2ctsb_pkg::ACT_STOP, 8'hFF, 8'hFF);
      add_event(i2ctsb_pkg::ACT_ADDR_READ, 8'h00, 8'h00);
      add_event(i2ctsb_pkg::ACT_MASTER_READ, 8'hFF, 8'hFF);
      add_event(i2ctsb_pkg::ACT_ADDR_WRITE, 8'h00, 8'h00);
      add_event(i2ctsb_pkg::ACT_MASTER_WRITE, 8'h00, 8'h00);
      add_event(i2ctsb_pkg::ACT_MASTER_WRITE, 8'hFF, 8'hFF);
      add_event(i2ctsb_pkg::ACT_MASTER_WRITE, 8'hA5, 8'h5A);
      add_event(i2ctsb_pkg::ACT_STOP, 8'h00, 8'h00);
      add_event(i2ctsb_pkg::ACT_READ_RX, 8'h00, 8'h00);
      add_event(i2ctsb_pkg::ACT_READ_RX, 8'hFF, 8'h01);
      add_event(i2ctsb_pkg::ACT_READ_RX, 8'h00, 8'h02);
      add_event(i2ctsb_pkg::ACT_LOAD_SEND, 8'hFF, 8'h00);
      add_event(i2ctsb_pkg::ACT_LOAD_SEND, 8'h00, 8'hFF);
      add_event(i2ctsb_pkg::ACT_LOAD_SEND, 8'h5A, 8'h01);
      add_event(i2ctsb_pkg::ACT_ADDR_READ, 8'hFF, 8'hFF);

      // Two tiny segments: overflow on the second byte, rotation, then a short send.
      configure(2, 2, 2);
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      add_event(i2ctsb_pkg::ACT_ADDR_WRITE, 8'h00, 8'h00);
      add_event(i2ctsb_pkg::ACT_MASTER_WRITE, 8'h3C, 8'h00);
      add_event(i2ctsb_pkg::ACT_MASTER_WRITE, 8'hC3, 8'h00);
      add_event(i2ctsb_pkg::ACT_STOP, 8'h00, 8'h00);
      add_event(i2ctsb_pkg::ACT_ADDR_WRITE, 8'h00, 8'h00);
      add_event(i2ctsb_pkg::ACT_MASTER_WRITE, 8'h96, 8'h00);
      add_event(i2ctsb_pkg::ACT_STOP, 8'h00, 8'h00);
      add_event(i2ctsb_pkg::ACT_ADDR_READ, 8'h00, 8'h00);
      add_event(i2ctsb_pkg::ACT_MASTER_READ, 8'h00, 8'h00);
      add_event(i2ctsb_pkg::ACT_MASTER_READ, 8'h00, 8'h00);
      random_traffic(120);

      configure(4, 256, 2);
      random_traffic(200);
      configure(256, 256, 1);
      random_traffic(220);
      configure(0, 1, 2);
      random_traffic(180);
      configure(511, 0, 3);
      random_traffic(200);
      configure(3, 7, 0);
      random_traffic(200);
      configure(17, 511, 2);
      random_traffic(200);
      configure(1, 2, 2);
      random_traffic(150);
      configure(9, 64, 1);
      calm = 1'b1;
      random_traffic(150);

      wait_drained();
      repeat (8) @(posedge clock);
      if (awaited_outcomes.size() != 0) begin
         $error("%0d predicted results never arrived", awaited_outcomes.size());
         mismatches++;
      end
      $display("run: %0d bus events checked under %0d register settings", results_seen,
               settings_used + 1);
      $display("run: %0d segment reports, %0d filler sends, %0d dropped receive bytes",
               segment_reports, filler_sends, dropped_bytes);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
